// File: rtl/c3ad_pkg.sv
// ----------------------------------------------------------------------------
// c3ad_pkg
// Shared types and fixed constants for the complex3 axpy/dot accumulate unit.
// ----------------------------------------------------------------------------
package c3ad_pkg;

  localparam int SLOT_W  = 32;  // one half of a packed complex word
  localparam int WORD_W  = 64;  // packed complex word
  localparam int SCALE_W = 32;  // Q8.24 multiplier
  localparam int ACC_W   = 64;  // Q40.24 running sum
  localparam int FRAC_W  = 24;  // fraction bits of every fixed-point value
  localparam int HALF_LSB = 1 << (FRAC_W - 1);  // round-half-up constant

  // Pipeline control that rides along with each request
  typedef struct packed {
    logic vld;
    logic last;
  } ctl_t;

endpackage

// File: rtl/c3ad_lane.sv
// ----------------------------------------------------------------------------
// c3ad_lane
// One color component: axpy update of both halves, then p * t' for both
// halves summed exactly. Four register stages, advanced by en_i.
// ----------------------------------------------------------------------------
module c3ad_lane #(
  parameter int COMP_WIDTH = 32
) (
  input  logic                                clk_i,
  input  logic                                en_i,
  input  logic signed [c3ad_pkg::SCALE_W-1:0] scale_i,
  input  logic [c3ad_pkg::WORD_W-1:0]         p_word_i,
  input  logic [c3ad_pkg::WORD_W-1:0]         t_word_i,
  output logic [c3ad_pkg::WORD_W-1:0]         new_t_o,
  output logic signed [2*COMP_WIDTH:0]        sum_o,
  output logic                                sat_o
);

  localparam int ProdW = c3ad_pkg::SCALE_W + COMP_WIDTH;
  localparam int RndW  = ProdW + 1;
  localparam int ShW   = RndW - c3ad_pkg::FRAC_W;
  localparam int UpdW  = ShW + 1;
  localparam int DotW  = 2 * COMP_WIDTH;
  localparam int SumW  = DotW + 1;
  localparam logic signed [COMP_WIDTH-1:0] MaxV = {1'b0, {(COMP_WIDTH-1){1'b1}}};
  localparam logic signed [COMP_WIDTH-1:0] MinV = {1'b1, {(COMP_WIDTH-1){1'b0}}};

  // index 0 is the real half, index 1 the imaginary half
  logic signed [COMP_WIDTH-1:0] p_h [2];
  logic signed [COMP_WIDTH-1:0] t_h [2];

  logic signed [ProdW-1:0]      prod_q [2];
  logic signed [COMP_WIDTH-1:0] pa_q   [2];
  logic signed [COMP_WIDTH-1:0] ta_q   [2];

  logic signed [COMP_WIDTH-1:0] pb_q   [2];
  logic signed [COMP_WIDTH-1:0] nr_d   [2];
  logic signed [COMP_WIDTH-1:0] nr_q   [2];
  logic [1:0]                   hsat_d;
  logic                         satb_q;

  logic signed [DotW-1:0]       prd_q  [2];
  logic signed [COMP_WIDTH-1:0] ntc_q  [2];
  logic                         satc_q;

  logic signed [SumW-1:0]       sum_q;
  logic signed [COMP_WIDTH-1:0] ntd_q  [2];
  logic                         satd_q;

  assign p_h[0] = $signed(p_word_i[c3ad_pkg::SLOT_W +: COMP_WIDTH]);
  assign p_h[1] = $signed(p_word_i[0 +: COMP_WIDTH]);
  assign t_h[0] = $signed(t_word_i[c3ad_pkg::SLOT_W +: COMP_WIDTH]);
  assign t_h[1] = $signed(t_word_i[0 +: COMP_WIDTH]);

  for (genvar h = 0; h < 2; h++) begin : g_half
    logic signed [RndW-1:0] rnd;
    logic signed [ShW-1:0]  r;
    logic signed [UpdW-1:0] upd;
    logic [UpdW-COMP_WIDTH:0] top_bits;

    // round scale*p to 24 fraction bits, ties up, then add and clamp
    always_comb begin
      rnd      = RndW'(prod_q[h]) + RndW'(c3ad_pkg::HALF_LSB);
      r        = $signed(rnd[RndW-1:c3ad_pkg::FRAC_W]);
      upd      = UpdW'(ta_q[h]) + UpdW'(r);
      top_bits = upd[UpdW-1:COMP_WIDTH-1];
      hsat_d[h] = !((&top_bits) || !(|top_bits));
      if (!hsat_d[h]) begin
        nr_d[h] = upd[COMP_WIDTH-1:0];
      end else if (upd[UpdW-1]) begin
        nr_d[h] = MinV;
      end else begin
        nr_d[h] = MaxV;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        prod_q[h] <= ProdW'(scale_i) * ProdW'(p_h[h]);
        pa_q[h]   <= p_h[h];
        ta_q[h]   <= t_h[h];
        pb_q[h]   <= pa_q[h];
        nr_q[h]   <= nr_d[h];
        prd_q[h]  <= DotW'(pb_q[h]) * DotW'(nr_q[h]);
        ntc_q[h]  <= nr_q[h];
        ntd_q[h]  <= ntc_q[h];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      satb_q <= |hsat_d;
      satc_q <= satb_q;
      sum_q  <= SumW'(prd_q[0]) + SumW'(prd_q[1]);
      satd_q <= satc_q;
    end
  end

  assign new_t_o = {c3ad_pkg::SLOT_W'(ntd_q[0]), c3ad_pkg::SLOT_W'(ntd_q[1])};
  assign sum_o   = sum_q;
  assign sat_o   = satd_q;

endmodule

// File: rtl/c3ad_merge.sv
// ----------------------------------------------------------------------------
// c3ad_merge
// Combines the three lane sums into one rounded dot product, then adds it to
// the saturating running accumulator and holds the output register.
// ----------------------------------------------------------------------------
module c3ad_merge #(
  parameter int COMP_WIDTH = 32
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                en_i,
  input  c3ad_pkg::ctl_t                      ctl_i,
  input  logic signed [2*COMP_WIDTH:0]        sum0_i,
  input  logic signed [2*COMP_WIDTH:0]        sum1_i,
  input  logic signed [2*COMP_WIDTH:0]        sum2_i,
  input  logic [2:0]                          lane_sat_i,
  input  logic [3*c3ad_pkg::WORD_W-1:0]       new_t_i,
  output logic                                m_valid_o,
  output logic [3*c3ad_pkg::WORD_W-1:0]       m_new_t_o,
  output logic [c3ad_pkg::ACC_W-1:0]          m_dot_sum_o,
  output logic                                m_last_o,
  output logic                                m_sat_o
);

  localparam int SumW = 2 * COMP_WIDTH + 1;
  localparam int TotW = SumW + 3;
  localparam int DotRW = TotW - c3ad_pkg::FRAC_W;
  localparam int AccXW = c3ad_pkg::ACC_W + 1;
  localparam logic signed [c3ad_pkg::ACC_W-1:0] AccMax =
    {1'b0, {(c3ad_pkg::ACC_W-1){1'b1}}};
  localparam logic signed [c3ad_pkg::ACC_W-1:0] AccMin =
    {1'b1, {(c3ad_pkg::ACC_W-1){1'b0}}};

  logic signed [TotW-1:0]             tot;
  logic signed [DotRW-1:0]            dot_q;
  c3ad_pkg::ctl_t                     ctl_e_q;
  logic                               sat_e_q;
  logic [3*c3ad_pkg::WORD_W-1:0]      t_e_q;

  logic signed [AccXW-1:0]            acc_x;
  logic                               acc_ovf;
  logic signed [c3ad_pkg::ACC_W-1:0]  acc_new;
  logic signed [c3ad_pkg::ACC_W-1:0]  acc_q;

  logic                               m_valid_q;
  logic [3*c3ad_pkg::WORD_W-1:0]      m_new_t_q;
  logic [c3ad_pkg::ACC_W-1:0]         m_dot_q;
  logic                               m_last_q;
  logic                               m_sat_q;

  // exact sum of all six products, rounded once (ties up)
  assign tot = TotW'(sum0_i) + TotW'(sum1_i) + TotW'(sum2_i)
             + TotW'(c3ad_pkg::HALF_LSB);

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      dot_q   <= $signed(tot[TotW-1:c3ad_pkg::FRAC_W]);
      sat_e_q <= |lane_sat_i;
      t_e_q   <= new_t_i;
    end
  end

  always_comb begin
    acc_x   = AccXW'(acc_q) + AccXW'(dot_q);
    acc_ovf = acc_x[AccXW-1] ^ acc_x[AccXW-2];
    if (!acc_ovf) begin
      acc_new = acc_x[c3ad_pkg::ACC_W-1:0];
    end else if (acc_x[AccXW-1]) begin
      acc_new = AccMin;
    end else begin
      acc_new = AccMax;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctl_e_q   <= '0;
      m_valid_q <= 1'b0;
      acc_q     <= '0;
    end else if (en_i) begin
      ctl_e_q   <= ctl_i;
      m_valid_q <= ctl_e_q.vld;
      if (ctl_e_q.vld) begin
        acc_q <= ctl_e_q.last ? '0 : acc_new;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i && ctl_e_q.vld) begin
      m_new_t_q <= t_e_q;
      m_dot_q   <= acc_new;
      m_last_q  <= ctl_e_q.last;
      m_sat_q   <= sat_e_q | acc_ovf;
    end
  end

  assign m_valid_o   = m_valid_q;
  assign m_new_t_o   = m_new_t_q;
  assign m_dot_sum_o = m_dot_q;
  assign m_last_o    = m_last_q;
  assign m_sat_o     = m_sat_q;

  // a pass total leaves the accumulator cleared
  a_last_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_valid_q && m_last_q |-> acc_q == '0)
    else $error("accumulator not cleared after last site");

  // a saturated sum must raise the flag
  a_acc_sat_flag: assert property (@(posedge clk_i) disable iff (!rst_ni)
    en_i && ctl_e_q.vld && acc_ovf |=> m_valid_q && m_sat_q)
    else $error("accumulator saturation not flagged");

endmodule

// File: rtl/complex3_axpy_dot_accumulate_unit.sv
// ----------------------------------------------------------------------------
// complex3_axpy_dot_accumulate_unit
// Fused t' = t + scale*p over three complex lanes with a running, saturating
// real dot product of p and t'.
// An accepted request passes the lane stages, the merge register and then the output register.
// Throughput: one request per cycle; the whole pipeline holds while a
// finished result waits in the output register.
// Reset clears scale, the accumulator and all valid bits; it is asynchronous.
// ----------------------------------------------------------------------------
module complex3_axpy_dot_accumulate_unit #(
  parameter int COMP_WIDTH = 32
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         cfg_we_i,
  input  logic [31:0]  cfg_wdata_i,     // scale, signed Q8.24
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  input  logic [383:0] s_axis_tdata,    // p_comp0, p_comp1, p_comp2, t_comp0, t_comp1, t_comp2
  input  logic         s_axis_tlast,    // last_site
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  output logic [255:0] m_axis_tdata,    // new_t0, new_t1, new_t2, dot_sum
  output logic         m_axis_tlast,    // sum_done
  output logic         m_axis_tuser     // sat_flag
);

  localparam int NumLanes = 3;
  localparam int WordW = c3ad_pkg::WORD_W;

  logic                                en;
  logic signed [c3ad_pkg::SCALE_W-1:0] scale_q;
  c3ad_pkg::ctl_t                      ctl_q [4];
  logic signed [2*COMP_WIDTH:0]        lane_sum [NumLanes];
  logic [NumLanes-1:0]                 lane_sat;
  logic [NumLanes*WordW-1:0]           lane_t;
  logic [NumLanes*WordW-1:0]           out_t;
  logic [c3ad_pkg::ACC_W-1:0]          out_dot;

  assign en            = !m_axis_tvalid || m_axis_tready;
  assign s_axis_tready = en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      scale_q <= '0;
    end else if (cfg_we_i) begin
      scale_q <= $signed(cfg_wdata_i);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < 4; i++) begin
        ctl_q[i] <= '0;
      end
    end else if (en) begin
      ctl_q[0] <= '{vld: s_axis_tvalid, last: s_axis_tlast};
      for (int i = 1; i < 4; i++) begin
        ctl_q[i] <= ctl_q[i-1];
      end
    end
  end

  for (genvar l = 0; l < NumLanes; l++) begin : g_lane
    c3ad_lane #(
      .COMP_WIDTH (COMP_WIDTH)
    ) u_lane (
      .clk_i    (clk_i),
      .en_i     (en),
      .scale_i  (scale_q),
      .p_word_i (s_axis_tdata[l*WordW +: WordW]),
      .t_word_i (s_axis_tdata[(NumLanes+l)*WordW +: WordW]),
      .new_t_o  (lane_t[l*WordW +: WordW]),
      .sum_o    (lane_sum[l]),
      .sat_o    (lane_sat[l])
    );
  end

  c3ad_merge #(
    .COMP_WIDTH (COMP_WIDTH)
  ) u_merge (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .en_i        (en),
    .ctl_i       (ctl_q[3]),
    .sum0_i      (lane_sum[0]),
    .sum1_i      (lane_sum[1]),
    .sum2_i      (lane_sum[2]),
    .lane_sat_i  (lane_sat),
    .new_t_i     (lane_t),
    .m_valid_o   (m_axis_tvalid),
    .m_new_t_o   (out_t),
    .m_dot_sum_o (out_dot),
    .m_last_o    (m_axis_tlast),
    .m_sat_o     (m_axis_tuser)
  );

  assign m_axis_tdata = {out_dot, out_t};

  // an accepted request enters the first stage
  a_req_enters: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> ctl_q[0].vld)
    else $error("accepted request lost at pipeline entry");

  // a stalled output freezes the lane pipeline
  a_stall_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> $stable(ctl_q[3]) && $stable(ctl_q[0]))
    else $error("pipeline moved during output stall");

endmodule
